// ===== src/pfr_pkg.sv =====
// Package for the prefetch tracking ring: field widths, ring entry type,
// the operation and state codes, and the saturating counter helper.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package pfr_pkg;

  localparam int unsigned DefRingDepth = 256;
  localparam int unsigned LayerW       = 8;
  localparam int unsigned ExpertW      = 10;
  localparam int unsigned TotalW       = 32;
  localparam int unsigned PendW        = 9;

  typedef enum logic {
    OP_ISSUE = 1'b0,
    OP_MARK  = 1'b1
  } op_e;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic [LayerW-1:0]  layer;
    logic [ExpertW-1:0] expert;
    logic               used;
  } entry_t;

  // Control that the sequencer hands to the chain of entry cells.
  typedef struct packed {
    logic   shift;
    entry_t feed;
    entry_t wdata;
  } ring_ctrl_t;

  function automatic logic [TotalW-1:0] sat_inc(input logic [TotalW-1:0] v);
    logic [TotalW-1:0] r;
    r = (v == {TotalW{1'b1}}) ? v : v + TotalW'(1);
    return r;
  endfunction

endpackage

// ===== src/pfr_cell.sv =====
// One entry cell of the prefetch tracking ring.
// Takes a new entry on a write, else its neighbor's entry on a shift.
// Depends on pfr_pkg.
`timescale 1ns / 1ps

module pfr_cell (
  input  logic            clk_i,
  input  logic            shift_i,
  input  logic            load_i,
  input  pfr_pkg::entry_t nbr_i,
  input  pfr_pkg::entry_t wdata_i,
  output pfr_pkg::entry_t entry_o
);

  pfr_pkg::entry_t entry_q;
  pfr_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (load_i) begin
      entry_d = wdata_i;
    end else if (shift_i) begin
      entry_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// ===== src/pfr_ring.sv =====
// Chain of entry cells; cell 0 holds the oldest entry except while a scan rotates the chain.
// A shift moves every entry one cell toward the head, the feed entering the tail.
// Depends on pfr_pkg and pfr_cell.
`timescale 1ns / 1ps

module pfr_ring #(
  parameter int unsigned RingDepth = pfr_pkg::DefRingDepth
) (
  input  logic                   clk_i,
  input  pfr_pkg::ring_ctrl_t    ctrl_i,
  input  logic [RingDepth-1:0]   load_i,
  output pfr_pkg::entry_t        head_o
);

  pfr_pkg::entry_t cell_q [RingDepth];

  for (genvar i = 0; i < RingDepth; i++) begin : g_cell
    pfr_pkg::entry_t nbr;
    if (i == RingDepth - 1) begin : g_tail
      assign nbr = ctrl_i.feed;
    end else begin : g_body
      assign nbr = cell_q[i+1];
    end

    pfr_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (ctrl_i.shift),
      .load_i  (load_i[i]),
      .nbr_i   (nbr),
      .wdata_i (ctrl_i.wdata),
      .entry_o (cell_q[i])
    );
  end

  assign head_o = cell_q[0];

endmodule

// ===== src/prefetch_tracking_ring_core.sv =====
// Prefetch tracking ring: the result of an issue or a disabled request strobes on
// result_valid_o in the cycle after start_i is taken.
// A mark request scans while every entry circulates once past the compare at the
// head of the cell chain; its result strobes in the cycle after the last scan step.
// busy_o is high during the scan. Results cannot be held off; the totals and pending
// count are valid during the strobe cycle. No clearing pass is needed after reset.
// Depends on pfr_pkg and pfr_ring.
`timescale 1ns / 1ps

module prefetch_tracking_ring_core #(
  parameter int unsigned RingDepth = pfr_pkg::DefRingDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          op_i,
  input  logic [pfr_pkg::LayerW-1:0]    layer_i,
  input  logic [pfr_pkg::ExpertW-1:0]   expert_i,
  input  logic                          already_cached_i,
  input  logic                          last_expert_i,
  output logic                          result_valid_o,
  output logic                          hint_sent_o,
  output logic [pfr_pkg::LayerW-1:0]    hint_layer_o,
  output logic [pfr_pkg::ExpertW-1:0]   hint_expert_o,
  output logic                          matched_o,
  output logic                          evicted_unused_o,
  output logic [pfr_pkg::PendW-1:0]     pending_entries_o,
  output logic [pfr_pkg::TotalW-1:0]    issued_total_o,
  output logic [pfr_pkg::TotalW-1:0]    hit_total_o,
  output logic [pfr_pkg::TotalW-1:0]    wasted_total_o
);

  localparam int unsigned CntW  = $clog2(RingDepth + 1);
  localparam int unsigned StepW = $clog2(RingDepth);

  pfr_pkg::state_e state_q, state_d;

  logic                        enable_q;
  logic [CntW-1:0]             count_q, count_d;
  logic [StepW-1:0]            step_q, step_d;
  logic                        found_q, found_d;
  logic [pfr_pkg::LayerW-1:0]  key_layer_q, key_layer_d;
  logic [pfr_pkg::ExpertW-1:0] key_expert_q, key_expert_d;
  logic [pfr_pkg::TotalW-1:0]  issued_q, issued_d;
  logic [pfr_pkg::TotalW-1:0]  hit_q, hit_d;
  logic [pfr_pkg::TotalW-1:0]  wasted_q, wasted_d;

  logic                        res_valid_q, res_valid_d;
  logic                        res_hint_q, res_hint_d;
  logic [pfr_pkg::LayerW-1:0]  res_layer_q, res_layer_d;
  logic [pfr_pkg::ExpertW-1:0] res_expert_q, res_expert_d;
  logic                        res_match_q, res_match_d;
  logic                        res_evict_q, res_evict_d;

  pfr_pkg::ring_ctrl_t  ring_ctrl;
  logic [RingDepth-1:0] load_en;
  pfr_pkg::entry_t      head;
  pfr_pkg::entry_t      new_entry;
  logic                 accept;
  logic                 append;
  logic                 full;
  logic                 in_range;
  logic                 hit;
  logic                 last_step;
  logic [CntW+pfr_pkg::PendW-1:0] count_ext;

  assign accept    = start_i && (state_q == pfr_pkg::ST_IDLE);
  assign full      = (count_q == CntW'(RingDepth));
  assign last_step = (step_q == StepW'(RingDepth - 1));
  assign in_range  = ({1'b0, step_q} < (StepW+1)'(count_q));
  assign hit       = in_range && !found_q && !head.used &&
                     (head.layer == key_layer_q) && (head.expert == key_expert_q);

  always_comb begin
    new_entry        = '0;
    new_entry.layer  = layer_i;
    new_entry.expert = expert_i;
  end

  pfr_ring #(
    .RingDepth (RingDepth)
  ) u_ring (
    .clk_i  (clk_i),
    .ctrl_i (ring_ctrl),
    .load_i (load_en),
    .head_o (head)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfr_pkg::ST_IDLE: begin
        if (accept && enable_q && (op_i == pfr_pkg::OP_MARK)) begin
          state_d = pfr_pkg::ST_SCAN;
        end
      end
      pfr_pkg::ST_SCAN: begin
        if (last_step) begin
          state_d = pfr_pkg::ST_IDLE;
        end
      end
      default: state_d = pfr_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and result.
  always_comb begin
    ring_ctrl.shift = 1'b0;
    ring_ctrl.feed  = head;
    ring_ctrl.wdata = new_entry;
    append          = 1'b0;
    count_d         = count_q;
    step_d          = step_q;
    found_d         = found_q;
    key_layer_d     = key_layer_q;
    key_expert_d    = key_expert_q;
    issued_d        = issued_q;
    hit_d           = hit_q;
    wasted_d        = wasted_q;
    res_valid_d     = 1'b0;
    res_hint_d      = 1'b0;
    res_layer_d     = '0;
    res_expert_d    = '0;
    res_match_d     = 1'b0;
    res_evict_d     = 1'b0;
    case (state_q)
      pfr_pkg::ST_IDLE: begin
        if (accept) begin
          res_valid_d = 1'b1;
          if (enable_q && (op_i == pfr_pkg::OP_MARK)) begin
            res_valid_d  = 1'b0;
            key_layer_d  = layer_i;
            key_expert_d = expert_i;
            step_d       = '0;
            found_d      = 1'b0;
          end else if (enable_q && !already_cached_i) begin
            res_hint_d   = 1'b1;
            res_layer_d  = layer_i;
            res_expert_d = expert_i;
            issued_d     = pfr_pkg::sat_inc(issued_q);
            if (full) begin
              // Drop the oldest entry off the head and enter the new one at the tail.
              ring_ctrl.shift = 1'b1;
              ring_ctrl.feed  = new_entry;
              if (!head.used) begin
                res_evict_d = 1'b1;
                wasted_d    = pfr_pkg::sat_inc(wasted_q);
              end
            end else begin
              append  = 1'b1;
              count_d = count_q + CntW'(1);
            end
          end
        end
      end
      pfr_pkg::ST_SCAN: begin
        // Rotate the whole chain once; the head entry re-enters at the tail.
        ring_ctrl.shift     = 1'b1;
        ring_ctrl.feed.used = head.used | hit;
        step_d              = step_q + StepW'(1);
        if (hit) begin
          found_d = 1'b1;
          hit_d   = pfr_pkg::sat_inc(hit_q);
        end
        if (last_step) begin
          res_valid_d = 1'b1;
          res_match_d = found_q | hit;
        end
      end
      default: begin
        res_valid_d = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < RingDepth; i++) begin
      load_en[i] = append && (count_q == CntW'(i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfr_pkg::ST_IDLE;
      enable_q    <= 1'b0;
      count_q     <= '0;
      step_q      <= '0;
      found_q     <= 1'b0;
      issued_q    <= '0;
      hit_q       <= '0;
      wasted_q    <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      found_q     <= found_d;
      issued_q    <= issued_d;
      hit_q       <= hit_d;
      wasted_q    <= wasted_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        enable_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_layer_q  <= key_layer_d;
    key_expert_q <= key_expert_d;
    if (res_valid_d) begin
      res_hint_q   <= res_hint_d;
      res_layer_q  <= res_layer_d;
      res_expert_q <= res_expert_d;
      res_match_q  <= res_match_d;
      res_evict_q  <= res_evict_d;
    end
  end

  // The batch marker carries no meaning for the tracking itself.
  logic unused_last_expert;
  assign unused_last_expert = last_expert_i;

  assign count_ext         = {{pfr_pkg::PendW{1'b0}}, count_q};
  assign busy_o            = (state_q != pfr_pkg::ST_IDLE);
  assign result_valid_o    = res_valid_q;
  assign hint_sent_o       = res_hint_q;
  assign hint_layer_o      = res_layer_q;
  assign hint_expert_o     = res_expert_q;
  assign matched_o         = res_match_q;
  assign evicted_unused_o  = res_evict_q;
  assign pending_entries_o = count_ext[pfr_pkg::PendW-1:0];
  assign issued_total_o    = issued_q;
  assign hit_total_o       = hit_q;
  assign wasted_total_o    = wasted_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(RingDepth))
    else $error("entry count exceeds ring depth");

  a_scan_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfr_pkg::ST_SCAN) && last_step |=>
      res_valid_q && (state_q == pfr_pkg::ST_IDLE))
    else $error("mark scan did not end with a result");

  a_scan_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pfr_pkg::ST_SCAN) |=> $stable(count_q) && $stable(issued_q))
    else $error("entry count or issue total changed during a scan");

  a_one_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q && (state_q == pfr_pkg::ST_SCAN) |-> !hit)
    else $error("second match within one scan");
`endif

endmodule

// ===== test/tb_prefetch_tracking_ring_core.sv =====
// Self-checking testbench for prefetch_tracking_ring_core: a directed table, then random
// request bursts with gaps; each result is held to the table or to a cycle-free model.
// Depends on pfr_pkg and the prefetch_tracking_ring_core RTL.
`timescale 1ns / 1ps

module tb_prefetch_tracking_ring_core;
  import pfr_pkg::*;

  localparam int unsigned Depth = DefRingDepth;

  typedef struct packed {
    op_e                op;
    logic [LayerW-1:0]  layer;
    logic [ExpertW-1:0] expert;
    logic               cached;
    logic               last;
  } request_t;

  // Field order matches the concatenation of result ports in the checker.
  typedef struct packed {
    logic               hint;
    logic [LayerW-1:0]  hint_layer;
    logic [ExpertW-1:0] hint_expert;
    logic               matched;
    logic               evicted;
    logic [PendW-1:0]   pending;
    logic [TotalW-1:0]  issued;
    logic [TotalW-1:0]  hits;
    logic [TotalW-1:0]  wasted;
  } ring_report_t;

  typedef enum logic {
    ROW_REQ,
    ROW_CFG
  } row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    logic         cfg_val;
    request_t     req;
    logic         typed;
    ring_report_t report;
  } stim_row_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                cfg_we_i         = 1'b0;
  logic                cfg_wdata_i      = 1'b0;
  logic                start_i          = 1'b0;
  logic                op_i             = 1'b0;
  logic [LayerW-1:0]   layer_i          = '0;
  logic [ExpertW-1:0]  expert_i         = '0;
  logic                already_cached_i = 1'b0;
  logic                last_expert_i    = 1'b0;
  logic                busy_o;
  logic                result_valid_o;
  logic                hint_sent_o;
  logic [LayerW-1:0]   hint_layer_o;
  logic [ExpertW-1:0]  hint_expert_o;
  logic                matched_o;
  logic                evicted_unused_o;
  logic [PendW-1:0]    pending_entries_o;
  logic [TotalW-1:0]   issued_total_o;
  logic [TotalW-1:0]   hit_total_o;
  logic [TotalW-1:0]   wasted_total_o;

  prefetch_tracking_ring_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .op_i             (op_i),
    .layer_i          (layer_i),
    .expert_i         (expert_i),
    .already_cached_i (already_cached_i),
    .last_expert_i    (last_expert_i),
    .result_valid_o   (result_valid_o),
    .hint_sent_o      (hint_sent_o),
    .hint_layer_o     (hint_layer_o),
    .hint_expert_o    (hint_expert_o),
    .matched_o        (matched_o),
    .evicted_unused_o (evicted_unused_o),
    .pending_entries_o(pending_entries_o),
    .issued_total_o   (issued_total_o),
    .hit_total_o      (hit_total_o),
    .wasted_total_o   (wasted_total_o)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the tracking ring.
  entry_t            ring_q [Depth];
  int unsigned       oldest;
  int unsigned       held;
  logic [TotalW-1:0] issued_cnt;
  logic [TotalW-1:0] hit_cnt;
  logic [TotalW-1:0] wasted_cnt;
  logic              track_en;

  ring_report_t        owed_reports [$];
  logic [17:0]         recent_pairs [$];
  stim_row_t           rows [$];
  int unsigned         mismatches;

  function automatic ring_report_t track_request(request_t r);
    ring_report_t o;
    int unsigned  slot;
    int unsigned  i;
    o = '0;
    if (track_en) begin
      if (r.op == OP_ISSUE) begin
        if (!r.cached) begin
          o.hint        = 1'b1;
          o.hint_layer  = r.layer;
          o.hint_expert = r.expert;
          if (issued_cnt != '1) issued_cnt++;
          if (held >= Depth) begin
            // Full ring: the oldest entry is overwritten and the head moves on.
            slot = oldest;
            if (!ring_q[slot].used) begin
              o.evicted = 1'b1;
              if (wasted_cnt != '1) wasted_cnt++;
            end
            oldest = (oldest + 1) % Depth;
          end else begin
            slot = (oldest + held) % Depth;
            held++;
          end
          ring_q[slot].layer  = r.layer;
          ring_q[slot].expert = r.expert;
          ring_q[slot].used   = 1'b0;
        end
      end else begin
        for (i = 0; i < held && !o.matched; i++) begin
          slot = (oldest + i) % Depth;
          if (ring_q[slot].layer == r.layer && ring_q[slot].expert == r.expert &&
              !ring_q[slot].used) begin
            ring_q[slot].used = 1'b1;
            o.matched = 1'b1;
            if (hit_cnt != '1) hit_cnt++;
          end
        end
      end
    end
    o.pending = PendW'(held);
    o.issued  = issued_cnt;
    o.hits    = hit_cnt;
    o.wasted  = wasted_cnt;
    return o;
  endfunction

  task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_report(input ring_report_t got);
    ring_report_t want;
    if (owed_reports.size() == 0) begin
      $display("%0t: result with no request outstanding, actual %h", $time, got);
      mismatches++;
      return;
    end
    want = owed_reports.pop_front();
    cmp_field("hint_sent", want.hint, got.hint);
    cmp_field("hint_layer", want.hint_layer, got.hint_layer);
    cmp_field("hint_expert", want.hint_expert, got.hint_expert);
    cmp_field("matched", want.matched, got.matched);
    cmp_field("evicted_unused", want.evicted, got.evicted);
    cmp_field("pending_entries", want.pending, got.pending);
    cmp_field("issued_total", want.issued, got.issued);
    cmp_field("hit_total", want.hits, got.hits);
    cmp_field("wasted_total", want.wasted, got.wasted);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      check_report({hint_sent_o, hint_layer_o, hint_expert_o, matched_o, evicted_unused_o,
                    pending_entries_o, issued_total_o, hit_total_o, wasted_total_o});
    end
  end

  // Leaves start_i high at the accepting edge; the caller lowers it for a gap.
  task automatic send_request(input request_t r, input logic typed, input ring_report_t want);
    ring_report_t calc;
    op_i             <= r.op;
    layer_i          <= r.layer;
    expert_i         <= r.expert;
    already_cached_i <= r.cached;
    last_expert_i    <= r.last;
    start_i          <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    calc = track_request(r);
    owed_reports.push_back(typed ? want : calc);
  endtask

  task automatic idle_cycles(input int unsigned n);
    if (n > 0) begin
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic set_enable(input logic v);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (owed_reports.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    track_en = v;
  endtask

  function automatic stim_row_t req_row(input op_e op, input int unsigned layer,
                                        input int unsigned expert, input logic cached,
                                        input logic last);
    stim_row_t s;
    s            = '0;
    s.kind       = ROW_REQ;
    s.req.op     = op;
    s.req.layer  = LayerW'(layer);
    s.req.expert = ExpertW'(expert);
    s.req.cached = cached;
    s.req.last   = last;
    return s;
  endfunction

  function automatic stim_row_t cfg_row(input logic v);
    stim_row_t s;
    s         = '0;
    s.kind    = ROW_CFG;
    s.cfg_val = v;
    return s;
  endfunction

  function automatic stim_row_t with_report(input stim_row_t s, input logic hint,
                                            input int unsigned hl, input int unsigned he,
                                            input logic m, input int unsigned pend,
                                            input int unsigned iss, input int unsigned hit);
    stim_row_t t;
    t                    = s;
    t.typed              = 1'b1;
    t.report             = '0;
    t.report.hint        = hint;
    t.report.hint_layer  = LayerW'(hl);
    t.report.hint_expert = ExpertW'(he);
    t.report.matched     = m;
    t.report.pending     = PendW'(pend);
    t.report.issued      = iss;
    t.report.hits        = hit;
    return t;
  endfunction

  // Mostly issues and marks of recently hinted pairs, with some stray marks as noise.
  function automatic request_t random_request();
    request_t    r;
    int unsigned pick;
    logic [17:0] pair;
    pick     = $urandom_range(0, 99);
    r.last   = ($urandom_range(0, 7) == 0);
    r.cached = ($urandom_range(0, 4) == 0);
    pair     = {8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023))};
    if (pick < 55) begin
      r.op = OP_ISSUE;
      if (recent_pairs.size() != 0 && $urandom_range(0, 3) == 0)
        pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
      if (!r.cached) begin
        recent_pairs.push_back(pair);
        if (recent_pairs.size() > 48) void'(recent_pairs.pop_front());
      end
    end else begin
      r.op = OP_MARK;
      if (pick < 92 && recent_pairs.size() != 0)
        pair = recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
    end
    r.layer  = pair[17:10];
    r.expert = pair[9:0];
    return r;
  endfunction

  task automatic run_phase(input logic en, input int unsigned n);
    int unsigned burst;
    request_t    r;
    set_enable(en);
    burst = $urandom_range(1, 12);
    repeat (n) begin
      r = random_request();
      send_request(r, 1'b0, '0);
      burst--;
      if (burst == 0) begin
        idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15));
        burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    oldest     = 0;
    held       = 0;
    issued_cnt = '0;
    hit_cnt    = '0;
    wasted_cnt = '0;
    track_en   = 1'b0;
    mismatches = 0;

    // Disabled after reset: everything reads zero.
    rows.push_back(with_report(req_row(OP_ISSUE, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(with_report(req_row(OP_MARK, 255, 1023, 1, 1), 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(cfg_row(1'b1));
    rows.push_back(with_report(req_row(OP_ISSUE, 0, 0, 0, 0), 1, 0, 0, 0, 1, 1, 0));
    rows.push_back(with_report(req_row(OP_ISSUE, 255, 1023, 0, 1), 1, 255, 1023, 0, 2, 2, 0));
    // A cached pair sends no hint and leaves the ring alone.
    rows.push_back(with_report(req_row(OP_ISSUE, 255, 1023, 1, 0), 0, 0, 0, 0, 2, 2, 0));
    rows.push_back(with_report(req_row(OP_MARK, 255, 1023, 0, 0), 0, 0, 0, 1, 2, 2, 1));
    // The same pair again finds only a used entry.
    rows.push_back(with_report(req_row(OP_MARK, 255, 1023, 0, 0), 0, 0, 0, 0, 2, 2, 1));
    rows.push_back(with_report(req_row(OP_MARK, 0, 0, 1, 1), 0, 0, 0, 1, 2, 2, 2));
    // Duplicate entries are consumed oldest first, then the mark misses.
    rows.push_back(req_row(OP_ISSUE, 'h55, 'h2aa, 0, 0));
    rows.push_back(req_row(OP_ISSUE, 'h55, 'h2aa, 0, 1));
    rows.push_back(req_row(OP_MARK, 'h55, 'h2aa, 0, 0));
    rows.push_back(req_row(OP_MARK, 'h55, 'h2aa, 0, 0));
    rows.push_back(req_row(OP_MARK, 'h55, 'h2aa, 0, 0));
    rows.push_back(req_row(OP_MARK, 'haa, 'h155, 0, 0));
    rows.push_back(req_row(OP_ISSUE, 'haa, 'h155, 1, 0));
    rows.push_back(cfg_row(1'b0));
    rows.push_back(req_row(OP_ISSUE, 1, 1, 0, 0));
    rows.push_back(req_row(OP_MARK, 0, 0, 0, 0));
    rows.push_back(cfg_row(1'b1));
    rows.push_back(req_row(OP_MARK, 1, 1, 0, 1));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        set_enable(rows[i].cfg_val);
      end else begin
        send_request(rows[i].req, rows[i].typed, rows[i].report);
        idle_cycles($urandom_range(0, 2));
      end
    end

    run_phase(1'b1, 800);
    run_phase(1'b0, 60);
    run_phase(1'b1, 500);
    run_phase(1'b1, 400);

    start_i <= 1'b0;
    @(posedge clk_i);
    while (owed_reports.size() != 0) @(posedge clk_i);
    // A stray strobe would still show up within one full scan.
    repeat (Depth + 8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS prefetch_tracking_ring_core");
    end else begin
      $display("FAIL prefetch_tracking_ring_core");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("FAIL prefetch_tracking_ring_core");
    $finish;
  end

endmodule
